### rtl/wcfb_pkg.sv
// ----------------------------------------------------------------------------
// wcfb_pkg
// shared types, constants and helpers for the byte-wise cfb stream cipher
// ----------------------------------------------------------------------------
`default_nettype none

package wcfb_pkg;

    localparam int WordW    = 32;
    localparam int AddrW    = 9;     // 257-entry table
    localparam int TblTop   = 256;
    localparam int TblDepth = TblTop + 1;

    localparam logic [31:0] ZOr   = 32'h0100_0001;
    localparam logic [31:0] ZAnd  = 32'hff7f_ffff;
    localparam logic [31:0] Low24 = 32'h00ff_ffff;

    // register indexes of the write port
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_DIR  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_MIX_INIT,
        ST_MIX_LATCH,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_MIX_TOP,
        ST_PERM_RD,
        ST_PERM_V,
        ST_PERM_W1,
        ST_PERM_W2,
        ST_BYTE,
        ST_CH_RD,
        ST_CH_WR
    } state_t;

    typedef struct packed {
        logic             we;
        logic [AddrW-1:0] waddr;
        logic [WordW-1:0] wdata;
        logic [AddrW-1:0] raddr0;
        logic [AddrW-1:0] raddr1;
    } ram_req_t;

    function automatic logic [31:0] mix_const(input logic [2:0] sel);
        logic [31:0] c;
        case (sel)
            3'd0:    c = 32'h726a_8f3b;
            3'd1:    c = 32'he69a_3b5c;
            3'd2:    c = 32'hd3c7_1fe5;
            3'd3:    c = 32'hab3c_73d2;
            3'd4:    c = 32'h4d3a_8eb3;
            3'd5:    c = 32'h0396_d6e8;
            3'd6:    c = 32'h3d4c_2f7a;
            default: c = 32'h9ee2_7cf3;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/wcfb_ram.sv
// ----------------------------------------------------------------------------
// wcfb_ram
// s-table memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module wcfb_ram (
    input  wire logic                   clk,
    input  wire wcfb_pkg::ram_req_t     req,
    output logic [wcfb_pkg::WordW-1:0]  rdata0,
    output logic [wcfb_pkg::WordW-1:0]  rdata1
);

    logic [wcfb_pkg::WordW-1:0] mem [wcfb_pkg::TblDepth];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata0 <= mem[req.raddr0];
        rdata1 <= mem[req.raddr1];
    end

endmodule

`default_nettype wire

### rtl/wake_cfb_byte_cipher_top.sv
// ----------------------------------------------------------------------------
// wake_cfb_byte_cipher_top
// wake stream cipher, byte-wise cipher feedback, sequenced over one s-table
// ----------------------------------------------------------------------------
// after accept a byte is ciphered in ST_BYTE, which loads the output register once it is free
// every fourth byte adds four dependent table reads (the chain steps)
// a restart (or the first byte after reset) adds a key expansion
//   (generate 256 words, fold 23, mix 256 plus the top entry, permute 256, one table port pair)
// one item at a time; input not ready until the item's work is done
// reset clears control, feedback, shift word and forces expansion first
`default_nettype none

module wake_cfb_byte_cipher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  wire logic        s_axis_tuser,   // [0] restart
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_out
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_data
);

    wcfb_pkg::state_t state_reg, state_next;

    // configuration
    logic [31:0] key_reg [4];
    logic        dir_reg;

    // cipher state
    logic [31:0] fw_reg [4];       // feedback r3..r6, rotated during chain steps
    logic [31:0] shift_reg;
    logic [1:0]  pos_reg;
    logic        tbl_ok_reg;

    // sequencer working registers
    logic [7:0]  cnt_reg;
    logic [31:0] win_reg [4];      // last four generated words
    logic [31:0] v_reg;
    logic [31:0] z_reg;
    logic [31:0] t0_reg;
    logic [31:0] tn_reg;
    logic [31:0] sum_reg;
    logic [31:0] prev_reg;         // chain input b
    logic [7:0]  din_reg;

    logic        ov_reg;
    logic [7:0]  od_reg;

    wcfb_pkg::ram_req_t ram_req;
    logic [31:0] rd0, rd1;

    wcfb_ram u_ram (
        .clk    (clk),
        .req    (ram_req),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    // datapath helpers
    logic [31:0] gen_sum, gen_val, mix_v, mix_val, ch_sum;
    logic [7:0]  perm_v, ks, dout, fbb;
    logic [31:0] shift_new;
    logic        out_free;

    always_comb
    begin
        gen_sum = win_reg[0] + win_reg[3];
        gen_val = (cnt_reg < 8'd4) ? key_reg[cnt_reg[1:0]]
                : ((gen_sum >> 3) ^ wcfb_pkg::mix_const(gen_sum[2:0]));
        mix_v   = (v_reg & wcfb_pkg::ZAnd) + z_reg;
        mix_val = (rd0 & wcfb_pkg::Low24) ^ mix_v;
        perm_v  = rd0[7:0] ^ v_reg[7:0];
        ch_sum  = fw_reg[0] + prev_reg;
        ks      = fw_reg[3][{pos_reg, 3'b000} +: 8];
        dout    = din_reg ^ ks;
        fbb     = dir_reg ? din_reg : dout;
        shift_new = shift_reg;
        shift_new[{pos_reg, 3'b000} +: 8] = fbb;
        out_free = !ov_reg || m_axis_tready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wcfb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = (s_axis_tuser || !tbl_ok_reg) ? wcfb_pkg::ST_GEN
                                                               : wcfb_pkg::ST_BYTE;
                end
            end
            wcfb_pkg::ST_GEN:
                if (cnt_reg == 8'd255) state_next = wcfb_pkg::ST_ADD_RD;
            wcfb_pkg::ST_ADD_RD:    state_next = wcfb_pkg::ST_ADD_WR;
            wcfb_pkg::ST_ADD_WR:
                state_next = (cnt_reg == 8'd22) ? wcfb_pkg::ST_MIX_INIT
                                                : wcfb_pkg::ST_ADD_RD;
            wcfb_pkg::ST_MIX_INIT:  state_next = wcfb_pkg::ST_MIX_LATCH;
            wcfb_pkg::ST_MIX_LATCH: state_next = wcfb_pkg::ST_MIX_RD;
            wcfb_pkg::ST_MIX_RD:    state_next = wcfb_pkg::ST_MIX_WR;
            wcfb_pkg::ST_MIX_WR:
                state_next = (cnt_reg == 8'd255) ? wcfb_pkg::ST_MIX_TOP
                                                 : wcfb_pkg::ST_MIX_RD;
            wcfb_pkg::ST_MIX_TOP:   state_next = wcfb_pkg::ST_PERM_RD;
            wcfb_pkg::ST_PERM_RD:   state_next = wcfb_pkg::ST_PERM_V;
            wcfb_pkg::ST_PERM_V:    state_next = wcfb_pkg::ST_PERM_W1;
            wcfb_pkg::ST_PERM_W1:   state_next = wcfb_pkg::ST_PERM_W2;
            wcfb_pkg::ST_PERM_W2:
                state_next = (cnt_reg == 8'd255) ? wcfb_pkg::ST_BYTE
                                                 : wcfb_pkg::ST_PERM_RD;
            wcfb_pkg::ST_BYTE:
            begin
                if (out_free)
                begin
                    state_next = (pos_reg == 2'd3) ? wcfb_pkg::ST_CH_RD
                                                   : wcfb_pkg::ST_IDLE;
                end
            end
            wcfb_pkg::ST_CH_RD:     state_next = wcfb_pkg::ST_CH_WR;
            wcfb_pkg::ST_CH_WR:
                state_next = (cnt_reg == 8'd3) ? wcfb_pkg::ST_IDLE
                                               : wcfb_pkg::ST_CH_RD;
            default:                state_next = wcfb_pkg::ST_IDLE;
        endcase
    end

    // table port control
    always_comb
    begin
        ram_req = '0;
        s_axis_tready = (state_reg == wcfb_pkg::ST_IDLE);
        unique case (state_reg)
            wcfb_pkg::ST_GEN:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b0, cnt_reg};
                ram_req.wdata = gen_val;
            end
            wcfb_pkg::ST_ADD_RD:
            begin
                ram_req.raddr0 = {1'b0, cnt_reg};
                ram_req.raddr1 = {1'b0, cnt_reg} + 9'd89;
            end
            wcfb_pkg::ST_ADD_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b0, cnt_reg};
                ram_req.wdata = rd0 + rd1;
            end
            wcfb_pkg::ST_MIX_INIT:
            begin
                ram_req.raddr0 = 9'd33;
                ram_req.raddr1 = 9'd59;
            end
            wcfb_pkg::ST_MIX_RD:
                ram_req.raddr0 = {1'b0, cnt_reg};
            wcfb_pkg::ST_MIX_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b0, cnt_reg};
                ram_req.wdata = mix_val;
            end
            wcfb_pkg::ST_MIX_TOP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = 9'(wcfb_pkg::TblTop);
                ram_req.wdata = t0_reg;
            end
            wcfb_pkg::ST_PERM_RD:
                ram_req.raddr0 = {1'b0, cnt_reg ^ v_reg[7:0]};
            wcfb_pkg::ST_PERM_V:
            begin
                ram_req.raddr0 = {1'b0, perm_v};
                ram_req.raddr1 = {1'b0, cnt_reg} + 9'd1;
            end
            wcfb_pkg::ST_PERM_W1:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b0, cnt_reg};
                ram_req.wdata = rd0;
            end
            wcfb_pkg::ST_PERM_W2:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {1'b0, v_reg[7:0]};
                ram_req.wdata = tn_reg;
            end
            wcfb_pkg::ST_CH_RD:
                ram_req.raddr0 = {1'b0, ch_sum[7:0]};
            default:
                ram_req = '0;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wcfb_pkg::ST_IDLE;
            cnt_reg    <= '0;
            tbl_ok_reg <= 1'b0;
            pos_reg    <= '0;
            shift_reg  <= '0;
            dir_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
                fw_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    wcfb_pkg::REG_KEY0: key_reg[0] <= cfg_data;
                    wcfb_pkg::REG_KEY1: key_reg[1] <= cfg_data;
                    wcfb_pkg::REG_KEY2: key_reg[2] <= cfg_data;
                    wcfb_pkg::REG_KEY3: key_reg[3] <= cfg_data;
                    wcfb_pkg::REG_DIR:  dir_reg    <= cfg_data[0];
                    default: ;
                endcase
            end

            // output register: loaded by a finished byte, freed on accept
            if (state_reg == wcfb_pkg::ST_BYTE && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end

            case (state_reg)
                wcfb_pkg::ST_IDLE:
                    cnt_reg <= '0;
                wcfb_pkg::ST_GEN:
                    cnt_reg <= cnt_reg + 8'd1;
                wcfb_pkg::ST_ADD_WR:
                    cnt_reg <= (cnt_reg == 8'd22) ? 8'd0 : cnt_reg + 8'd1;
                wcfb_pkg::ST_MIX_WR:
                    cnt_reg <= cnt_reg + 8'd1;
                wcfb_pkg::ST_MIX_TOP:
                    cnt_reg <= '0;
                wcfb_pkg::ST_PERM_W2:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd255)
                    begin
                        // expansion done: reload feedback from the key
                        for (int i = 0; i < 4; i++)
                        begin
                            fw_reg[i] <= key_reg[i];
                        end
                        shift_reg  <= '0;
                        pos_reg    <= '0;
                        tbl_ok_reg <= 1'b1;
                    end
                end
                wcfb_pkg::ST_BYTE:
                begin
                    if (out_free)
                    begin
                        shift_reg <= shift_new;
                        pos_reg   <= pos_reg + 2'd1;
                        cnt_reg   <= '0;
                    end
                end
                wcfb_pkg::ST_CH_WR:
                begin
                    // rotate so the next word to update sits at the head
                    fw_reg[0] <= fw_reg[1];
                    fw_reg[1] <= fw_reg[2];
                    fw_reg[2] <= fw_reg[3];
                    fw_reg[3] <= (sum_reg >> 8) ^ rd0;
                    cnt_reg   <= cnt_reg + 8'd1;
                end
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wcfb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    din_reg <= s_axis_tdata;
                end
            end
            wcfb_pkg::ST_GEN:
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= win_reg[3];
                win_reg[3] <= gen_val;
            end
            wcfb_pkg::ST_MIX_LATCH:
            begin
                v_reg <= rd0;
                z_reg <= (rd1 | wcfb_pkg::ZOr) & wcfb_pkg::ZAnd;
            end
            wcfb_pkg::ST_MIX_WR:
            begin
                v_reg <= mix_v;
                if (cnt_reg == 8'd0)
                begin
                    t0_reg <= mix_val;
                end
            end
            wcfb_pkg::ST_MIX_TOP:
                v_reg <= {24'd0, v_reg[7:0]};
            wcfb_pkg::ST_PERM_V:
                v_reg <= {24'd0, perm_v};
            wcfb_pkg::ST_PERM_W1:
                tn_reg <= rd1;
            wcfb_pkg::ST_BYTE:
            begin
                if (out_free)
                begin
                    od_reg   <= dout;
                    prev_reg <= shift_new;
                end
            end
            wcfb_pkg::ST_CH_RD:
                sum_reg <= ch_sum;
            wcfb_pkg::ST_CH_WR:
                prev_reg <= (sum_reg >> 8) ^ rd0;
            default: ;
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

endmodule

`default_nettype wire
